@@ sv/pild_pkg.sv @@
// ---------------------------------------------------------------------------
// pild_pkg: shared types and constants for the packed index LUT decoder
// Payload structs, controller/datapath command and status, register indexes.
// ---------------------------------------------------------------------------
package pild_pkg;

  localparam int PILD_TABLE_DEPTH    = 1024;
  localparam int PILD_MAX_INDEX_BITS = 8;
  localparam int STREAM_WORD_BITS    = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_SIZE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENTS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALTERNATE_AXIS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_STRIDE   = 3'd5;

  // input transaction kinds
  localparam logic ACTION_TABLE_WRITE = 1'b0;
  localparam logic ACTION_STREAM_WORD = 1'b1;

  // value_size codes
  localparam logic [1:0] VSIZE_8  = 2'd0;
  localparam logic [1:0] VSIZE_16 = 2'd1;
  localparam logic [1:0] VSIZE_32 = 2'd2;
  localparam logic [1:0] VSIZE_64 = 2'd3;

  typedef struct packed {
    logic                        action;
    logic [9:0]                  table_address;
    logic [63:0]                 table_value;
    logic [STREAM_WORD_BITS-1:0] packed_word;
  } pild_in_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [7:0]  channel;
    logic        last_of_tensor;
  } pild_out_t;

  typedef struct packed {
    logic table_write;
    logic load_word;
    logic extract;
  } pild_cmd_t;

  typedef struct packed {
    logic can_extract;
    logic last;
  } pild_status_t;

endpackage

@@ sv/pild_ctrl.sv @@
// ---------------------------------------------------------------------------
// pild_ctrl: sequencer of the packed index LUT decoder
// Accepts transactions, steps index extraction and hands results out.
// ---------------------------------------------------------------------------
module pild_ctrl import pild_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         action,
  output logic         out_valid,
  input  logic         out_ready,
  input  pild_status_t status,
  output pild_cmd_t    cmd
);

  localparam int N_W = $clog2(STREAM_WORD_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]     state, state_next;
  logic [N_W-1:0] n_done, n_done_next;
  logic           under_cap;

  assign under_cap = n_done < N_W'(STREAM_WORD_BITS);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    state_next  = state;
    n_done_next = n_done;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACTION_TABLE_WRITE) begin
            cmd.table_write = 1'b1;
          end else begin
            cmd.load_word = 1'b1;
            n_done_next   = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (status.can_extract && under_cap) begin
          cmd.extract = 1'b1;
          n_done_next = n_done + N_W'(1);
          state_next  = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          state_next = status.last ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n_done <= '0;
    end else begin
      state  <= state_next;
      n_done <= n_done_next;
    end
  end

  a_extract_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.extract |=> out_valid)
    else $error("extraction not followed by a result");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && status.last |=> in_ready)
    else $error("tensor end did not return to idle");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    n_done <= N_W'(STREAM_WORD_BITS))
    else $error("too many results for one word");

endmodule

@@ sv/pild_datapath.sv @@
// ---------------------------------------------------------------------------
// pild_datapath: bit buffer, position counters and value table
// Unpacks indices, forms table addresses and holds the result registers.
// ---------------------------------------------------------------------------
module pild_datapath import pild_pkg::*; #(
  parameter int TABLE_DEPTH    = PILD_TABLE_DEPTH,
  parameter int MAX_INDEX_BITS = PILD_MAX_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  pild_in_t               in_item,
  input  pild_cmd_t              cmd,
  output pild_status_t           status,
  output pild_out_t              out_item
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int BUF_W  = MAX_INDEX_BITS - 1 + STREAM_WORD_BITS;
  localparam int CNT_W  = $clog2(BUF_W + 1);
  localparam int IB_W   = $clog2(MAX_INDEX_BITS + 1);
  localparam int W0     = (ADDR_W > MAX_INDEX_BITS) ? ADDR_W : MAX_INDEX_BITS;
  localparam int SUM_W  = ((W0 > 10) ? W0 : 10) + 1;

  // configuration registers
  logic [3:0]  index_bits;
  logic [1:0]  value_size;
  logic [8:0]  channel_count;
  logic [15:0] elements_per_channel;
  logic        alternate_axis;
  logic [8:0]  table_stride;

  // decode state
  logic [BUF_W-1:0]  bit_buffer;
  logic [CNT_W-1:0]  bit_count;
  logic [7:0]        channel_index;
  logic [15:0]       element_index;
  logic [ADDR_W-1:0] slice_base;

  // value table and result registers
  logic [63:0] table_mem [TABLE_DEPTH];
  logic [63:0] rdata;
  logic [7:0]  res_channel;
  logic        res_last;

  logic [IB_W-1:0]           eff_bits;
  logic [CNT_W-1:0]          bits_c;
  logic [CNT_W-1:0]          count_rem;
  logic [BUF_W-1:0]          shifted;
  logic [BUF_W-1:0]          keep_mask;
  logic [MAX_INDEX_BITS-1:0] idx_mask;
  logic [MAX_INDEX_BITS-1:0] idx;
  logic [8:0]                eff_chans;
  logic [15:0]               eff_elems;
  logic                      chan_end, elem_end, last_now;
  logic [ADDR_W-1:0]         rd_addr, wr_addr, base_step;
  logic [63:0]               vmask;

  always_comb begin
    if (index_bits == 4'd0) begin
      eff_bits = IB_W'(1);
    end else if (int'(index_bits) > MAX_INDEX_BITS) begin
      eff_bits = IB_W'(MAX_INDEX_BITS);
    end else begin
      eff_bits = IB_W'(index_bits);
    end
  end

  assign bits_c    = CNT_W'(eff_bits);
  assign count_rem = bit_count - bits_c;
  assign shifted   = bit_buffer >> count_rem;

  always_comb begin
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      idx_mask[i] = (i < int'(eff_bits));
    end
    for (int i = 0; i < BUF_W; i++) begin
      keep_mask[i] = (i < int'(count_rem));
    end
  end

  assign idx = shifted[MAX_INDEX_BITS-1:0] & idx_mask;

  // table depth is a power of two, so wrapping is truncation
  assign rd_addr   = ADDR_W'(SUM_W'(slice_base) + SUM_W'(idx));
  assign base_step = ADDR_W'(SUM_W'(slice_base) + SUM_W'(table_stride));
  assign wr_addr   = ADDR_W'(SUM_W'(in_item.table_address));

  assign eff_chans = (channel_count == 9'd0)  ? 9'd1 :
                     (channel_count > 9'd256) ? 9'd256 : channel_count;
  assign eff_elems = (elements_per_channel == 16'd0) ? 16'd1 : elements_per_channel;
  assign chan_end  = ({1'b0, channel_index} + 9'd1) >= eff_chans;
  assign elem_end  = ({1'b0, element_index} + 17'd1) >= {1'b0, eff_elems};
  assign last_now  = chan_end && elem_end;

  always_comb begin
    case (value_size)
      VSIZE_8:  vmask = 64'h0000_0000_0000_00FF;
      VSIZE_16: vmask = 64'h0000_0000_0000_FFFF;
      VSIZE_32: vmask = 64'h0000_0000_FFFF_FFFF;
      VSIZE_64: vmask = 64'hFFFF_FFFF_FFFF_FFFF;
      default:  vmask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  assign status.can_extract = bit_count >= bits_c;
  assign status.last        = res_last;

  assign out_item.decoded_value  = rdata & vmask;
  assign out_item.channel        = res_channel;
  assign out_item.last_of_tensor = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits           <= 4'd4;
      value_size           <= VSIZE_8;
      channel_count        <= 9'd1;
      elements_per_channel <= 16'd1;
      alternate_axis       <= 1'b0;
      table_stride         <= 9'd16;
      bit_buffer           <= '0;
      bit_count            <= '0;
      channel_index        <= '0;
      element_index        <= '0;
      slice_base           <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_INDEX_BITS:     index_bits           <= cfg_data[3:0];
          REG_VALUE_SIZE:     value_size           <= cfg_data[1:0];
          REG_CHANNEL_COUNT:  channel_count        <= cfg_data[8:0];
          REG_ELEMENTS:       elements_per_channel <= cfg_data[15:0];
          REG_ALTERNATE_AXIS: alternate_axis       <= cfg_data[0];
          REG_TABLE_STRIDE:   table_stride         <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (cmd.load_word) begin
        bit_buffer <= BUF_W'({bit_buffer, in_item.packed_word});
        bit_count  <= bit_count + CNT_W'(STREAM_WORD_BITS);
      end
      if (cmd.extract) begin
        if (last_now) begin
          // end of tensor: drop leftover bits, restart at channel 0
          bit_buffer    <= '0;
          bit_count     <= '0;
          channel_index <= '0;
          element_index <= '0;
          slice_base    <= '0;
        end else begin
          bit_buffer <= bit_buffer & keep_mask;
          bit_count  <= count_rem;
          if (alternate_axis) begin
            if (chan_end) begin
              channel_index <= '0;
              slice_base    <= '0;
              element_index <= element_index + 16'd1;
            end else begin
              channel_index <= channel_index + 8'd1;
              slice_base    <= base_step;
            end
          end else begin
            if (elem_end) begin
              element_index <= '0;
              channel_index <= channel_index + 8'd1;
              slice_base    <= base_step;
            end else begin
              element_index <= element_index + 16'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_write) begin
      table_mem[wr_addr] <= in_item.table_value;
    end
    if (cmd.extract) begin
      rdata       <= table_mem[rd_addr];
      res_channel <= channel_index;
      res_last    <= last_now;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(BUF_W))
    else $error("bit count beyond buffer width");

  a_tensor_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.extract && last_now |=> bit_count == '0 && channel_index == '0
      && element_index == '0)
    else $error("counters not cleared at tensor end");

endmodule

@@ sv/packed_index_lut_decoder.sv @@
// ---------------------------------------------------------------------------
// packed_index_lut_decoder: palettised value table decompressor
// Unpacks an MSB-first stream of narrow indices and looks each one up in
// the current channel's slice of a value table, one value per index.
// ---------------------------------------------------------------------------
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    pild_in_t  (table write or word)
//  out_*        out  out_valid/out_ready  pild_out_t (value, channel, last)
//  cfg_*        in   cfg_write            cfg_index, cfg_data
//
// A table write is taken in the idle state. A stream word is accepted, then
// per result the index is extracted with a table read and the result is
// held until it is handed over; the controller takes each result over
// before it extracts the next index.
// Reset (rst, synchronous) restores the register defaults and clears the
// bit buffer and counters; the value table is not cleared.
// A stall on out_ready holds the result and the decoder; no input
// transaction is taken until the word's results are all delivered.
//
module packed_index_lut_decoder import pild_pkg::*; #(
  parameter int TABLE_DEPTH    = PILD_TABLE_DEPTH,    // power of two
  parameter int MAX_INDEX_BITS = PILD_MAX_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pild_in_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pild_out_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pild_cmd_t    cmd;     // controller to datapath
  pild_status_t status;  // datapath to controller

  // Controller: idle / scan / emit sequencing, per-word result cap
  pild_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_item.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: config registers, bit buffer, channel/element counters,
  // slice base, value table and the result registers
  pild_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
